>>> sv/dlts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types and constants of the delta-list task scheduler: table sizing,
// field widths, request and status codes, sequencer states and entry layout.
// ----------------------------------------------------------------------------
package dlts_pkg;

   // table sizing
   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   // field widths
   localparam int MODE_W   = 2;
   localparam int HANDLE_W = 8;
   localparam int DATA_W   = 32;
   localparam int SUM_W    = DATA_W + 1;
   localparam int STATUS_W = 2;

   // request codes
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK     = 2'd0,
      MODE_ADD      = 2'd1,
      MODE_DELETE   = 2'd2,
      MODE_DISPATCH = 2'd3
   } mode_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NO_TASK   = 2'd2,
      STATUS_NOT_READY = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK,
      ST_WALK,
      ST_REL,
      ST_ADJ,
      ST_SHIFT_UP,
      ST_PLACE,
      ST_SHIFT_DN,
      ST_MERGE,
      ST_RESP
   } state_type;

   // one list entry
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [DATA_W-1:0]   delta;
      logic [DATA_W-1:0]   interval;
      logic                ready;
   } entry_type;

   // table write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } tbl_wr_type;

endpackage

>>> sv/dlts_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlts_table
// Entry table of the scheduler: one write port, one addressed read port and
// a fixed read of the list head.
// ----------------------------------------------------------------------------
module dlts_table (
   input  logic                      clock,
   input  logic [dlts_pkg::IDX_W-1:0] rd_addr,
   input  dlts_pkg::tbl_wr_type      wr,
   output dlts_pkg::entry_type       rd_data,
   output dlts_pkg::entry_type       head_data
);

   dlts_pkg::entry_type entry_ff [dlts_pkg::MAX_TASKS];

   // write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_ff[wr.addr] <= wr.data;
      end
   end

   // read the addressed entry and the head
   assign rd_data   = entry_ff[rd_addr];
   assign head_data = entry_ff[0];

endmodule

>>> sv/delta_list_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_task_scheduler
// Sorted delta list of timed tasks driven by a small sequencer around one
// shared 33-bit add/subtract unit; entries move one per cycle.
// ----------------------------------------------------------------------------
// The walk and the entry shifts, one table access a cycle, set the time from
//   accept to rsp_valid; for add, delete and dispatch it depends on
//   N, the number of tasks held (N up to MAX_TASKS).
// busy rises after accept and holds through the response; one request at a time.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
// Reset empties the list at once by clearing the task count; no clearing pass.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dlts_pkg::MODE_W-1:0]   req_mode,
   input  logic [dlts_pkg::HANDLE_W-1:0] req_task_handle,
   input  logic [dlts_pkg::DATA_W-1:0]   req_delay_ticks,
   input  logic [dlts_pkg::DATA_W-1:0]   req_period_ticks,
   input  logic [dlts_pkg::IDX_W-1:0]    req_slot_index,
   output logic                          busy,
   output logic                          rsp_valid,
   output logic [dlts_pkg::CNT_W-1:0]    rsp_slot,
   output logic [dlts_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_run_valid,
   output logic [dlts_pkg::HANDLE_W-1:0] rsp_run_task
);

   localparam int IDX_W = dlts_pkg::IDX_W;
   localparam int CNT_W = dlts_pkg::CNT_W;
   localparam int SUM_W = dlts_pkg::SUM_W;
   localparam int DATA_W = dlts_pkg::DATA_W;

   dlts_pkg::state_type  state_ff, state_in;
   dlts_pkg::mode_type   mode_ff, mode_in;
   dlts_pkg::status_type status_ff, status_in;

   logic [dlts_pkg::HANDLE_W-1:0] handle_ff, handle_in;
   logic [DATA_W-1:0]             delay_ff, delay_in;
   logic [DATA_W-1:0]             period_ff, period_in;
   logic                          ready_init_ff, ready_init_in;
   logic                          reinsert_ff, reinsert_in;
   logic [IDX_W-1:0]              pos_ff, pos_in;
   logic [IDX_W-1:0]              ptr_ff, ptr_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [DATA_W-1:0]             rel_ff, rel_in;
   logic [DATA_W-1:0]             moved_ff, moved_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              slot_ff, slot_in;
   logic                          run_valid_ff, run_valid_in;
   logic [dlts_pkg::HANDLE_W-1:0] run_task_ff, run_task_in;

   logic [IDX_W-1:0]     rd_addr;
   dlts_pkg::entry_type  rd_data;
   dlts_pkg::entry_type  head_data;
   dlts_pkg::tbl_wr_type wr;

   logic [SUM_W-1:0] alu_a;
   logic [SUM_W-1:0] alu_b;
   logic             alu_sub;
   logic [SUM_W-1:0] alu_y;

   logic [CNT_W-1:0] pos_ext;
   logic [CNT_W-1:0] ptr_ext;
   logic [CNT_W-1:0] ptr_next;
   logic             accept;

   assign pos_ext  = CNT_W'(pos_ff);
   assign ptr_ext  = CNT_W'(ptr_ff);
   assign ptr_next = ptr_ext + CNT_W'(1);
   assign accept   = start && (state_ff == dlts_pkg::ST_IDLE);

   dlts_table u_table (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .wr        (wr),
      .rd_data   (rd_data),
      .head_data (head_data)
   );

   // steer the shared add/subtract unit
   always_comb begin
      alu_a   = sum_ff;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         dlts_pkg::ST_TICK: begin
            alu_a   = SUM_W'(head_data.delta);
            alu_b   = SUM_W'(1);
            alu_sub = 1'b1;
         end
         dlts_pkg::ST_WALK: begin
            alu_a = sum_ff;
            alu_b = SUM_W'(rd_data.delta);
         end
         dlts_pkg::ST_REL: begin
            alu_a   = SUM_W'(delay_ff);
            alu_b   = sum_ff;
            alu_sub = 1'b1;
         end
         dlts_pkg::ST_ADJ: begin
            alu_a   = SUM_W'(rd_data.delta);
            alu_b   = SUM_W'(rel_ff);
            alu_sub = 1'b1;
         end
         dlts_pkg::ST_MERGE: begin
            alu_a = SUM_W'(rd_data.delta);
            alu_b = SUM_W'(moved_ff);
         end
         default: begin
            alu_a = sum_ff;
         end
      endcase
      alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   end

   // pick the table read address
   always_comb begin
      unique case (state_ff)
         dlts_pkg::ST_IDLE:     rd_addr = req_slot_index;
         dlts_pkg::ST_SHIFT_UP: rd_addr = IDX_W'(ptr_ext - CNT_W'(1));
         dlts_pkg::ST_SHIFT_DN: rd_addr = ptr_next[IDX_W-1:0];
         default:               rd_addr = pos_ff;
      endcase
   end

   // sequencer: next state, table writes and response fields
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      status_in     = status_ff;
      handle_in     = handle_ff;
      delay_in      = delay_ff;
      period_in     = period_ff;
      ready_init_in = ready_init_ff;
      reinsert_in   = reinsert_ff;
      pos_in        = pos_ff;
      ptr_in        = ptr_ff;
      sum_in        = sum_ff;
      rel_in        = rel_ff;
      moved_in      = moved_ff;
      count_in      = count_ff;
      slot_in       = slot_ff;
      run_valid_in  = run_valid_ff;
      run_task_in   = run_task_ff;
      wr            = '0;
      wr.data       = rd_data;

      unique case (state_ff)
         dlts_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in       = dlts_pkg::mode_type'(req_mode);
               handle_in     = req_task_handle;
               delay_in      = req_delay_ticks;
               period_in     = req_period_ticks;
               ready_init_in = (req_delay_ticks == '0);
               reinsert_in   = 1'b0;
               pos_in        = '0;
               sum_in        = '0;
               status_in     = dlts_pkg::STATUS_OK;
               slot_in       = '0;
               run_valid_in  = 1'b0;
               run_task_in   = '0;
               unique case (dlts_pkg::mode_type'(req_mode))
                  dlts_pkg::MODE_TICK: begin
                     state_in = dlts_pkg::ST_TICK;
                  end
                  dlts_pkg::MODE_ADD: begin
                     if (count_ff == CNT_W'(dlts_pkg::MAX_TASKS)) begin
                        slot_in   = CNT_W'(dlts_pkg::MAX_TASKS);
                        status_in = dlts_pkg::STATUS_FULL;
                        state_in  = dlts_pkg::ST_RESP;
                     end else begin
                        state_in = dlts_pkg::ST_WALK;
                     end
                  end
                  dlts_pkg::MODE_DELETE: begin
                     if (CNT_W'(req_slot_index) < count_ff) begin
                        pos_in   = req_slot_index;
                        ptr_in   = req_slot_index;
                        moved_in = rd_data.delta;
                        state_in = dlts_pkg::ST_SHIFT_DN;
                     end else begin
                        status_in = dlts_pkg::STATUS_NO_TASK;
                        state_in  = dlts_pkg::ST_RESP;
                     end
                  end
                  dlts_pkg::MODE_DISPATCH: begin
                     if (count_ff != '0 && head_data.ready) begin
                        run_valid_in  = 1'b1;
                        run_task_in   = head_data.handle;
                        handle_in     = head_data.handle;
                        delay_in      = head_data.interval;
                        period_in     = head_data.interval;
                        ready_init_in = 1'b0;
                        reinsert_in   = (head_data.interval != '0);
                        ptr_in        = '0;
                        moved_in      = head_data.delta;
                        state_in      = dlts_pkg::ST_SHIFT_DN;
                     end else begin
                        status_in = dlts_pkg::STATUS_NOT_READY;
                        state_in  = dlts_pkg::ST_RESP;
                     end
                  end
               endcase
            end
         end

         // count down the head only, or mark it ready once its delta is zero
         dlts_pkg::ST_TICK: begin
            if (count_ff != '0 && !head_data.ready) begin
               wr.en   = 1'b1;
               wr.addr = '0;
               wr.data = head_data;
               if (head_data.delta == '0) begin
                  wr.data.ready = 1'b1;
               end else begin
                  wr.data.delta = alu_y[DATA_W-1:0];
               end
            end
            state_in = dlts_pkg::ST_RESP;
         end

         // advance past every entry due no later than the new task
         dlts_pkg::ST_WALK: begin
            if (pos_ext < count_ff && !(SUM_W'(delay_ff) < alu_y)) begin
               sum_in = alu_y;
               pos_in = pos_ff + IDX_W'(1);
            end else begin
               state_in = dlts_pkg::ST_REL;
            end
         end

         // form the delay relative to the predecessor
         dlts_pkg::ST_REL: begin
            rel_in = alu_y[DATA_W-1:0];
            ptr_in = count_ff[IDX_W-1:0];
            state_in = (pos_ext < count_ff) ? dlts_pkg::ST_ADJ : dlts_pkg::ST_SHIFT_UP;
         end

         // shorten the successor's delta
         dlts_pkg::ST_ADJ: begin
            wr.en         = 1'b1;
            wr.addr       = pos_ff;
            wr.data.delta = alu_y[DATA_W-1:0];
            state_in      = dlts_pkg::ST_SHIFT_UP;
         end

         // open a gap at the insert position, last entry first
         dlts_pkg::ST_SHIFT_UP: begin
            if (ptr_ff > pos_ff) begin
               wr.en   = 1'b1;
               wr.addr = ptr_ff;
               ptr_in  = ptr_ff - IDX_W'(1);
            end else begin
               state_in = dlts_pkg::ST_PLACE;
            end
         end

         // write the new task
         dlts_pkg::ST_PLACE: begin
            wr.en            = 1'b1;
            wr.addr          = pos_ff;
            wr.data.handle   = handle_ff;
            wr.data.delta    = rel_ff;
            wr.data.interval = period_ff;
            wr.data.ready    = ready_init_ff;
            count_in         = count_ff + CNT_W'(1);
            if (mode_ff == dlts_pkg::MODE_ADD) begin
               slot_in = pos_ext;
            end
            state_in = dlts_pkg::ST_RESP;
         end

         // close the gap left by the removed entry
         dlts_pkg::ST_SHIFT_DN: begin
            if (ptr_next < count_ff) begin
               wr.en   = 1'b1;
               wr.addr = ptr_ff;
               ptr_in  = ptr_ff + IDX_W'(1);
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = dlts_pkg::ST_MERGE;
            end
         end

         // hand the removed delta to the successor, then reinsert if periodic
         dlts_pkg::ST_MERGE: begin
            if (pos_ext < count_ff) begin
               wr.en         = 1'b1;
               wr.addr       = pos_ff;
               wr.data.delta = alu_y[DATA_W-1:0];
            end
            if (reinsert_ff) begin
               reinsert_in = 1'b0;
               pos_in      = '0;
               sum_in      = '0;
               state_in    = dlts_pkg::ST_WALK;
            end else begin
               state_in = dlts_pkg::ST_RESP;
            end
         end

         dlts_pkg::ST_RESP: begin
            state_in = dlts_pkg::ST_IDLE;
         end

         default: begin
            state_in = dlts_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dlts_pkg::ST_IDLE;
         count_ff    <= '0;
         reinsert_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         reinsert_ff <= reinsert_in;
      end
   end

   // working and response registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      status_ff     <= status_in;
      handle_ff     <= handle_in;
      delay_ff      <= delay_in;
      period_ff     <= period_in;
      ready_init_ff <= ready_init_in;
      pos_ff        <= pos_in;
      ptr_ff        <= ptr_in;
      sum_ff        <= sum_in;
      rel_ff        <= rel_in;
      moved_ff      <= moved_in;
      slot_ff       <= slot_in;
      run_valid_ff  <= run_valid_in;
      run_task_ff   <= run_task_in;
   end

   // drive ports
   assign busy          = (state_ff != dlts_pkg::ST_IDLE);
   assign rsp_valid     = (state_ff == dlts_pkg::ST_RESP);
   assign rsp_slot      = slot_ff;
   assign rsp_status    = status_ff;
   assign rsp_run_valid = run_valid_ff;
   assign rsp_run_task  = run_task_ff;

   // the list never holds more than its capacity
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(dlts_pkg::MAX_TASKS))
      else $error("task count beyond capacity");

   // the count moves by at most one per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (count_ff == $past(count_ff) + CNT_W'(1)) ||
                             (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("task count jumped");

   // an accepted request keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   // a released task always reports success
   a_run_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_valid |-> rsp_status == dlts_pkg::STATUS_OK)
      else $error("dispatch released a task with error status");

   // a response is followed by an idle cycle
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("response strobe longer than one cycle");

endmodule

>>> test/delta_list_task_scheduler_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_task_scheduler_check
// Watches the request and response channels of the delta-list scheduler. It
// keeps its own copy of the task list, predicts the response of every
// accepted request, and compares each strobed response field by field with
// the oldest pending prediction.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [dlts_pkg::MODE_W-1:0]   req_mode,
   input  logic [dlts_pkg::HANDLE_W-1:0] req_task_handle,
   input  logic [dlts_pkg::DATA_W-1:0]   req_delay_ticks,
   input  logic [dlts_pkg::DATA_W-1:0]   req_period_ticks,
   input  logic [dlts_pkg::IDX_W-1:0]    req_slot_index,
   input  logic                          rsp_valid,
   input  logic [dlts_pkg::CNT_W-1:0]    rsp_slot,
   input  logic [dlts_pkg::STATUS_W-1:0] rsp_status,
   input  logic                          rsp_run_valid,
   input  logic [dlts_pkg::HANDLE_W-1:0] rsp_run_task,
   output int                            fail_count,
   output int                            pending_count
);

   typedef struct packed {
      logic [dlts_pkg::CNT_W-1:0]    slot;
      dlts_pkg::status_type          status;
      logic                          run_valid;
      logic [dlts_pkg::HANDLE_W-1:0] run_task;
   } sched_result_type;

   // predicted task list
   dlts_pkg::entry_type tbl [dlts_pkg::MAX_TASKS];
   logic                slot_used [dlts_pkg::MAX_TASKS];
   int                  task_total;

   sched_result_type expected_responses [$];

   // insert a task at its due position, return the slot or MAX_TASKS when full
   function automatic logic [dlts_pkg::CNT_W-1:0] place_task(
         logic [dlts_pkg::HANDLE_W-1:0] handle,
         logic [dlts_pkg::DATA_W-1:0]   delay,
         logic [dlts_pkg::DATA_W-1:0]   period);
      logic [63:0]                 due_sum;
      logic [dlts_pkg::DATA_W-1:0] rel;
      int                          pos;
      int                          j;
      due_sum = '0;
      pos     = 0;
      if (task_total >= dlts_pkg::MAX_TASKS) begin
         return dlts_pkg::CNT_W'(dlts_pkg::MAX_TASKS);
      end
      // walk past every entry due no later than the new task
      while (pos < task_total &&
             {32'd0, delay} >= due_sum + {32'd0, tbl[pos].delta}) begin
         due_sum = due_sum + {32'd0, tbl[pos].delta};
         pos++;
      end
      rel = delay - due_sum[dlts_pkg::DATA_W-1:0];
      if (pos < task_total) begin
         tbl[pos].delta = tbl[pos].delta - rel;
      end
      // open a hole at pos
      for (j = task_total; j > pos; j--) begin
         tbl[j]       = tbl[j-1];
         slot_used[j] = slot_used[j-1];
      end
      slot_used[pos]    = 1'b1;
      tbl[pos].handle   = handle;
      tbl[pos].delta    = rel;
      tbl[pos].interval = period;
      tbl[pos].ready    = (delay == '0);
      task_total++;
      return pos[dlts_pkg::CNT_W-1:0];
   endfunction

   // remove an entry and hand its delta to the successor
   function automatic void unlink_task(int pos);
      logic [dlts_pkg::DATA_W-1:0] moved;
      int                          i;
      moved = tbl[pos].delta;
      for (i = pos; i + 1 < task_total; i++) begin
         tbl[i]       = tbl[i+1];
         slot_used[i] = slot_used[i+1];
      end
      tbl[task_total-1]       = '0;
      slot_used[task_total-1] = 1'b0;
      task_total--;
      if (pos < task_total) begin
         tbl[pos].delta = tbl[pos].delta + moved;
      end
   endfunction

   // advance the predicted list by one request and return its response
   function automatic sched_result_type predict_schedule(
         dlts_pkg::mode_type            mode,
         logic [dlts_pkg::HANDLE_W-1:0] handle,
         logic [dlts_pkg::DATA_W-1:0]   delay,
         logic [dlts_pkg::DATA_W-1:0]   period,
         logic [dlts_pkg::IDX_W-1:0]    idx);
      sched_result_type              res;
      logic [dlts_pkg::HANDLE_W-1:0] head_handle;
      logic [dlts_pkg::DATA_W-1:0]   head_period;
      res        = '0;
      res.status = dlts_pkg::STATUS_OK;
      unique case (mode)
         dlts_pkg::MODE_TICK: begin
            // count down only a waiting head
            if (task_total > 0 && slot_used[0] && !tbl[0].ready) begin
               if (tbl[0].delta == '0) begin
                  tbl[0].ready = 1'b1;
               end else begin
                  tbl[0].delta = tbl[0].delta - 1'b1;
               end
            end
         end
         dlts_pkg::MODE_ADD: begin
            res.slot = place_task(handle, delay, period);
            if (res.slot >= dlts_pkg::MAX_TASKS) begin
               res.status = dlts_pkg::STATUS_FULL;
            end
         end
         dlts_pkg::MODE_DELETE: begin
            if (idx < task_total && slot_used[idx]) begin
               unlink_task(int'(idx));
            end else begin
               res.status = dlts_pkg::STATUS_NO_TASK;
            end
         end
         default: begin
            // release the ready head, put a periodic task back one period on
            if (task_total > 0 && slot_used[0] && tbl[0].ready) begin
               head_handle   = tbl[0].handle;
               head_period   = tbl[0].interval;
               res.run_valid = 1'b1;
               res.run_task  = head_handle;
               unlink_task(0);
               if (head_period != '0) begin
                  void'(place_task(head_handle, head_period, head_period));
               end
            end else begin
               res.status = dlts_pkg::STATUS_NOT_READY;
            end
         end
      endcase
      return res;
   endfunction

   // compare responses, then record newly accepted requests
   always @(posedge clock) begin : watch
      sched_result_type want;
      int               k;
      if (reset) begin
         for (k = 0; k < dlts_pkg::MAX_TASKS; k++) begin
            tbl[k]       = '0;
            slot_used[k] = 1'b0;
         end
         task_total = 0;
         expected_responses.delete();
         fail_count    = 0;
         pending_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request pending: slot %0d status %0d",
                      rsp_slot, rsp_status);
               fail_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_slot !== want.slot) begin
                  $error("rsp_slot mismatch: expected %0d, actual %0d",
                         want.slot, rsp_slot);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("rsp_status mismatch: expected %0d, actual %0d",
                         want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_run_valid !== want.run_valid) begin
                  $error("rsp_run_valid mismatch: expected %0d, actual %0d",
                         want.run_valid, rsp_run_valid);
                  fail_count++;
               end
               if (rsp_run_task !== want.run_task) begin
                  $error("rsp_run_task mismatch: expected %0d, actual %0d",
                         want.run_task, rsp_run_task);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            expected_responses.push_back(predict_schedule(
               dlts_pkg::mode_type'(req_mode), req_task_handle, req_delay_ticks,
               req_period_ticks, req_slot_index));
         end
         pending_count = expected_responses.size();
      end
   end

endmodule

>>> test/delta_list_task_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_task_scheduler_tb
// Drives the delta-list scheduler with a directed sequence (empty list, ready
// and periodic tasks, extreme delays, a full list, bad deletes) followed by
// random requests in fill, drain and mixed phases with random gaps. A
// separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler_tb;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic [dlts_pkg::MODE_W-1:0]   req_mode = '0;
   logic [dlts_pkg::HANDLE_W-1:0] req_task_handle = '0;
   logic [dlts_pkg::DATA_W-1:0]   req_delay_ticks = '0;
   logic [dlts_pkg::DATA_W-1:0]   req_period_ticks = '0;
   logic [dlts_pkg::IDX_W-1:0]    req_slot_index = '0;
   logic                          busy;
   logic                          rsp_valid;
   logic [dlts_pkg::CNT_W-1:0]    rsp_slot;
   logic [dlts_pkg::STATUS_W-1:0] rsp_status;
   logic                          rsp_run_valid;
   logic [dlts_pkg::HANDLE_W-1:0] rsp_run_task;
   int                            fail_count;
   int                            pending_count;

   delta_list_task_scheduler uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_mode         (req_mode),
      .req_task_handle  (req_task_handle),
      .req_delay_ticks  (req_delay_ticks),
      .req_period_ticks (req_period_ticks),
      .req_slot_index   (req_slot_index),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_slot         (rsp_slot),
      .rsp_status       (rsp_status),
      .rsp_run_valid    (rsp_run_valid),
      .rsp_run_task     (rsp_run_task)
   );

   delta_list_task_scheduler_check u_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_task_handle  (req_task_handle),
      .req_delay_ticks  (req_delay_ticks),
      .req_period_ticks (req_period_ticks),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_slot         (rsp_slot),
      .rsp_status       (rsp_status),
      .rsp_run_valid    (rsp_run_valid),
      .rsp_run_task     (rsp_run_task),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // end a hung run
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // idle, raise start with the request, hold it until accepted;
   // called and returns at a falling edge, start still high
   task automatic send_request(input int idle_cycles, input dlts_pkg::mode_type mode,
                               input logic [dlts_pkg::HANDLE_W-1:0] handle,
                               input logic [dlts_pkg::DATA_W-1:0] delay,
                               input logic [dlts_pkg::DATA_W-1:0] period,
                               input logic [dlts_pkg::IDX_W-1:0] idx);
      if (idle_cycles > 0) begin
         start = 1'b0;
         repeat (idle_cycles) @(negedge clock);
      end
      start            = 1'b1;
      req_mode         = mode;
      req_task_handle  = handle;
      req_delay_ticks  = delay;
      req_period_ticks = period;
      req_slot_index   = idx;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int                          n;
      int                          phase;
      bit                          steady;
      int                          roll;
      int                          gap;
      dlts_pkg::mode_type          mode;
      logic [dlts_pkg::DATA_W-1:0] delay;
      logic [dlts_pkg::DATA_W-1:0] period;
      logic [dlts_pkg::IDX_W-1:0]  idx;

      // hold reset, then release it at a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list: tick, dispatch and delete do nothing
      send_request(0, dlts_pkg::MODE_TICK, 8'd7, 32'd0, 32'd0, 4'd0);
      send_request(0, dlts_pkg::MODE_DISPATCH, 8'd7, 32'd0, 32'd0, 4'd0);
      send_request(0, dlts_pkg::MODE_DELETE, 8'd7, 32'd0, 32'd0, 4'd0);
      // zero delay is ready at once
      send_request(0, dlts_pkg::MODE_ADD, 8'd255, 32'd0, 32'd0, 4'd0);
      send_request(2, dlts_pkg::MODE_DISPATCH, 8'd0, 32'd0, 32'd0, 4'd0);
      // periodic task added with zero delay comes back one period later
      send_request(0, dlts_pkg::MODE_ADD, 8'd1, 32'd0, 32'd1, 4'd15);
      send_request(0, dlts_pkg::MODE_DISPATCH, 8'd0, 32'd0, 32'd0, 4'd0);
      send_request(0, dlts_pkg::MODE_TICK, 8'd0, 32'd0, 32'd0, 4'd0);
      send_request(0, dlts_pkg::MODE_TICK, 8'd0, 32'd0, 32'd0, 4'd0);
      send_request(0, dlts_pkg::MODE_DISPATCH, 8'd0, 32'd0, 32'd0, 4'd0);
      // handle zero and the largest delay and period
      send_request(0, dlts_pkg::MODE_ADD, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
      // fill the list, equal due times included
      for (n = 0; n < 14; n++) begin
         send_request(0, dlts_pkg::MODE_ADD, 8'(n + 16), 32'(n % 4), 32'(n % 3), 4'd0);
      end
      // one more add overflows the list
      send_request(0, dlts_pkg::MODE_ADD, 8'hAA, 32'd5, 32'd0, 4'd0);
      // delete the last slot of a full list
      send_request(0, dlts_pkg::MODE_DELETE, 8'd0, 32'd0, 32'd0, 4'd15);

      // random requests in phases
      phase  = 2;
      steady = 1'b0;
      for (n = 0; n < 700; n++) begin
         if (n % 40 == 0) begin
            phase  = $urandom_range(0, 2);
            steady = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         if (phase == 0) begin
            mode = dlts_pkg::mode_type'((roll < 20) ? dlts_pkg::MODE_TICK :
                   (roll < 80) ? dlts_pkg::MODE_ADD :
                   (roll < 90) ? dlts_pkg::MODE_DISPATCH : dlts_pkg::MODE_DELETE);
         end else if (phase == 1) begin
            mode = dlts_pkg::mode_type'((roll < 40) ? dlts_pkg::MODE_TICK :
                   (roll < 45) ? dlts_pkg::MODE_ADD :
                   (roll < 80) ? dlts_pkg::MODE_DISPATCH : dlts_pkg::MODE_DELETE);
         end else begin
            mode = dlts_pkg::mode_type'((roll < 30) ? dlts_pkg::MODE_TICK :
                   (roll < 60) ? dlts_pkg::MODE_ADD :
                   (roll < 85) ? dlts_pkg::MODE_DISPATCH : dlts_pkg::MODE_DELETE);
         end
         // mostly short delays so ticks bring tasks due
         roll = $urandom_range(0, 99);
         delay = (roll < 10) ? 32'd0 : (roll < 70) ? 32'($urandom_range(1, 6)) :
                 (roll < 85) ? 32'($urandom_range(7, 40)) :
                 (roll < 95) ? 32'($urandom) : 32'hFFFF_FFFF;
         roll = $urandom_range(0, 99);
         period = (roll < 45) ? 32'd0 : (roll < 85) ? 32'($urandom_range(1, 8)) :
                  (roll < 96) ? 32'($urandom) : 32'hFFFF_FFFF;
         idx = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 3)) :
                                              4'($urandom_range(0, 15));
         // gaps: mostly none or short, a few long
         roll = $urandom_range(0, 99);
         gap  = steady ? 0 : (roll < 60) ? 0 : (roll < 90) ? $urandom_range(1, 4) :
                $urandom_range(10, 60);
         send_request(gap, mode, 8'($urandom_range(1, 255)), delay, period, idx);
      end
      start = 1'b0;

      // drain outstanding responses, then let the block settle
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
